// ===== rtl/lbwu_pkg.sv =====
// Shared types, constants and helpers for the low-bit weight unpacker.
// No dependencies; used by lbwu_slicer and low_bit_weight_unpacker.
package lbwu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WidthW = 4;
  localparam int unsigned CarryW = 7;
  localparam int unsigned AccW   = CarryW + ByteW;
  localparam int unsigned CntW   = 4;

  localparam logic [WidthW-1:0] WidthNibble = 4'd4;
  localparam logic [WidthW-1:0] WidthByte   = 4'd8;

  typedef struct packed {
    logic [ByteW-1:0]  value;
    logic              last;
    logic [CntW-1:0]   rem_cnt;
    logic [CarryW-1:0] rem_bits;
  } slice_t;

  // Zero and anything above eight fall back to byte pass-through.
  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] w);
    logic [WidthW-1:0] r;
    r = w;
    if (w == '0 || w > WidthByte) r = WidthByte;
    return r;
  endfunction

  function automatic logic is_direct(input logic [WidthW-1:0] w);
    return (w == WidthNibble) || (w == WidthByte);
  endfunction

endpackage

// ===== rtl/lbwu_slicer.sv =====
// Field extraction: takes the top field of the working bits, converts it to
// a signed byte and reports what is left. Depends on lbwu_pkg.
module lbwu_slicer (
  input  logic [lbwu_pkg::AccW-1:0]   acc_i,
  input  logic [lbwu_pkg::CntW-1:0]   cnt_i,
  input  logic [lbwu_pkg::WidthW-1:0] width_i,
  output lbwu_pkg::slice_t            slice_o
);

  logic [lbwu_pkg::CntW-1:0]   shift;
  logic [lbwu_pkg::AccW-1:0]   shifted;
  logic [lbwu_pkg::ByteW-1:0]  mask;
  logic [lbwu_pkg::ByteW-1:0]  top;
  logic [lbwu_pkg::ByteW-1:0]  field;
  logic [lbwu_pkg::CarryW-1:0] rem_mask;
  logic [lbwu_pkg::CntW:0]     twice_w;

  assign shift   = cnt_i - width_i;
  assign shifted = acc_i >> shift;
  assign mask    = lbwu_pkg::ByteW'((9'd1 << width_i) - 9'd1);
  assign top     = lbwu_pkg::ByteW'(9'd1 << (width_i - 4'd1));
  assign twice_w = {1'b0, width_i} << 1;

  always_comb begin
    field = shifted[lbwu_pkg::ByteW-1:0] & mask;
    // biased widths: flipping the top bit turns u - 2^(w-1) into signed w bits
    if (!lbwu_pkg::is_direct(width_i)) field = field ^ top;
    if ((field & top) != '0) field = field | ~mask;
  end

  assign rem_mask = lbwu_pkg::CarryW'((8'd1 << shift) - 8'd1);

  assign slice_o.value    = field;
  assign slice_o.last     = {1'b0, cnt_i} < twice_w;
  assign slice_o.rem_cnt  = shift;
  assign slice_o.rem_bits = acc_i[lbwu_pkg::CarryW-1:0] & rem_mask;

endmodule

// ===== rtl/low_bit_weight_unpacker.sv =====
// Top level of the low-bit weight unpacker: input/carry registers, result
// register and config register. Depends on lbwu_pkg and lbwu_slicer.
//
//  channel   dir  payload                                    handshake
//  s_axis    in   tdata[7:0]=packed_byte, tlast=stream_end   tvalid/tready
//  m_axis    out  tdata[7:0]=weight_value, tlast=last_of_byte tvalid/tready
//  cfg       in   cfg_data_i[3:0]=weight_bits                cfg_valid_i/cfg_ready_o
//
// One result per cycle while a byte is held and m_axis is not stalled: a byte yields 1 result
// at width 8, 2 at width 4 and (carry + 8) / width otherwise, all from the single field slicer.
// A new byte is taken in the cycle its predecessor's last result enters the result register.
// Reset clears the carry and sets the width to 8; a config write clears the carry.
// A stalled result register holds the slicer; no results are dropped.
module low_bit_weight_unpacker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packed_byte
  input  logic        s_axis_tlast,   // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] weight_value
  output logic        m_axis_tlast,   // last_of_byte
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  logic [lbwu_pkg::WidthW-1:0] wbits_q;
  logic [lbwu_pkg::WidthW-1:0] width;
  logic                        have_q, have_d;
  logic [lbwu_pkg::AccW-1:0]   acc_q, acc_d;
  logic [lbwu_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                        end_q, end_d;
  logic [lbwu_pkg::CarryW-1:0] carry_bits_q, carry_bits_d;
  logic [2:0]                  carry_cnt_q, carry_cnt_d;
  logic                        m_valid_q;
  logic [lbwu_pkg::ByteW-1:0]  m_data_q;
  logic                        m_last_q;

  lbwu_pkg::slice_t            slice;
  logic                        adv;
  logic                        finish;
  logic                        accept;
  logic [lbwu_pkg::CarryW-1:0] src_bits;
  logic [2:0]                  src_cnt;

  assign width = lbwu_pkg::eff_width(wbits_q);

  lbwu_slicer u_slicer (
    .acc_i   (acc_q),
    .cnt_i   (cnt_q),
    .width_i (width),
    .slice_o (slice)
  );

  assign adv           = have_q && (!m_valid_q || m_axis_tready);
  assign finish        = adv && slice.last;
  assign s_axis_tready = !have_q || finish;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    carry_bits_d = carry_bits_q;
    carry_cnt_d  = carry_cnt_q;
    if (finish) begin
      if (end_q || lbwu_pkg::is_direct(width)) begin
        carry_bits_d = '0;
        carry_cnt_d  = '0;
      end else begin
        carry_bits_d = slice.rem_bits;
        carry_cnt_d  = slice.rem_cnt[2:0];
      end
    end
    src_bits = carry_bits_d;
    src_cnt  = carry_cnt_d;
  end

  always_comb begin
    have_d = have_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    end_d  = end_q;
    if (adv) begin
      cnt_d = slice.rem_cnt;
      if (slice.last) have_d = 1'b0;
    end
    if (accept) begin
      have_d = 1'b1;
      end_d  = s_axis_tlast;
      case (width)
        lbwu_pkg::WidthNibble: begin
          // low nibble first: swap so the MSB-first slicer sees it on top
          acc_d = {7'd0, s_axis_tdata[3:0], s_axis_tdata[7:4]};
          cnt_d = 4'd8;
        end
        lbwu_pkg::WidthByte: begin
          acc_d = {7'd0, s_axis_tdata};
          cnt_d = 4'd8;
        end
        default: begin
          acc_d = {src_bits, s_axis_tdata};
          cnt_d = {1'b0, src_cnt} + 4'd8;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbits_q      <= lbwu_pkg::WidthByte;
      have_q       <= 1'b0;
      carry_bits_q <= '0;
      carry_cnt_q  <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      have_q <= have_d;
      if (cfg_valid_i) begin
        wbits_q      <= cfg_data_i;
        carry_bits_q <= '0;
        carry_cnt_q  <= '0;
      end else begin
        carry_bits_q <= carry_bits_d;
        carry_cnt_q  <= carry_cnt_d;
      end
      if (adv) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    end_q <= end_d;
    if (adv) begin
      m_data_q <= slice.value;
      m_last_q <= slice.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  a_work_has_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_q |-> (cnt_q >= width))
    else $error("working byte holds fewer bits than one field");

  a_carry_below_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, carry_cnt_q} < width) || (carry_cnt_q == 3'd0))
    else $error("carry count reached the field width");

  a_carry_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (carry_bits_q >> carry_cnt_q) == '0)
    else $error("carry bits above the carry count");

endmodule

// ===== bench/low_bit_weight_unpacker_tb.sv =====
// Testbench for low_bit_weight_unpacker: directed table, then random byte runs at
// random widths, checked against a bit-accurate predictor of the unpacking.
// Depends on lbwu_pkg and the low_bit_weight_unpacker RTL.
module low_bit_weight_unpacker_tb;

  localparam int NumPhases  = 21;
  localparam int LongHold   = 150;
  localparam int DrainGap   = 4;
  localparam int EndGap     = 16;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } weight_res_t;

  // typed expectation: n_typed results, v0 then v1; zero means use the predictor
  typedef struct packed {
    logic       set_w;
    logic [3:0] width;
    logic [7:0] data;
    logic       eos;
    logic [1:0] n_typed;
    logic [7:0] v0;
    logic [7:0] v1;
  } vector_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] packed_byte
  logic       s_axis_tlast  = 1'b0;   // stream_end
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] weight_value
  logic       m_axis_tlast;           // last_of_byte
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i    = 4'd0;

  weight_res_t pending_weights [$];
  weight_res_t exp_w;
  logic [3:0]  model_width     = lbwu_pkg::WidthByte;
  logic [6:0]  model_carry     = '0;
  logic [2:0]  model_carry_cnt = '0;
  int          mismatches      = 0;
  int          cycles          = 0;
  int          hold_asks       = 0;
  int          holds_done      = 0;
  int          stall_left      = 0;
  logic        calm            = 1'b0;

  vector_t directed_vecs [0:24] = '{
    '{1'b0, 4'd8,  8'h00, 1'b0, 2'd1, 8'h00, 8'h00},
    '{1'b0, 4'd8,  8'hFF, 1'b0, 2'd1, 8'hFF, 8'h00},
    '{1'b0, 4'd8,  8'h7F, 1'b0, 2'd1, 8'h7F, 8'h00},
    '{1'b0, 4'd8,  8'h80, 1'b1, 2'd1, 8'h80, 8'h00},
    '{1'b1, 4'd4,  8'h8F, 1'b0, 2'd2, 8'hFF, 8'hF8},
    '{1'b0, 4'd4,  8'h70, 1'b1, 2'd2, 8'h00, 8'h07},
    '{1'b1, 4'd0,  8'hA5, 1'b0, 2'd1, 8'hA5, 8'h00},
    '{1'b1, 4'd15, 8'h3C, 1'b0, 2'd1, 8'h3C, 8'h00},
    '{1'b1, 4'd9,  8'h01, 1'b1, 2'd1, 8'h01, 8'h00},
    '{1'b1, 4'd1,  8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd1,  8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b1, 4'd2,  8'h1B, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd2,  8'hE4, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b1, 4'd3,  8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd3,  8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd3,  8'hAA, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd3,  8'h55, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b1, 4'd5,  8'hFF, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd5,  8'h81, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd5,  8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{1'b1, 4'd6,  8'hC3, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd6,  8'h3C, 1'b0, 2'd0, 8'h00, 8'h00},  // carry left pending
    '{1'b1, 4'd7,  8'hFE, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd7,  8'h01, 1'b0, 2'd0, 8'h00, 8'h00},
    '{1'b0, 4'd7,  8'h80, 1'b1, 2'd0, 8'h00, 8'h00}
  };

  low_bit_weight_unpacker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Unpacks one byte at the current width; queues the weights when keep is set.
  task automatic unpack_byte(input logic [7:0] data, input logic eos, input logic keep);
    weight_res_t outs [$];
    logic [3:0]  w;
    int unsigned cnt, acc, mask, bias;
    w = model_width;
    if (w == 4'd0 || w > lbwu_pkg::WidthByte) w = lbwu_pkg::WidthByte;
    if (w == lbwu_pkg::WidthByte) begin
      outs.push_back('{data, 1'b1});
      model_carry     = '0;
      model_carry_cnt = '0;
    end else if (w == lbwu_pkg::WidthNibble) begin
      outs.push_back('{{{4{data[3]}}, data[3:0]}, 1'b0});
      outs.push_back('{{{4{data[7]}}, data[7:4]}, 1'b1});
      model_carry     = '0;
      model_carry_cnt = '0;
    end else begin
      cnt  = model_carry_cnt + 8;
      acc  = {model_carry, data};
      mask = (1 << w) - 1;
      bias = 1 << (w - 1);
      while (cnt >= w && outs.size() < 8) begin
        outs.push_back('{8'(((acc >> (cnt - w)) & mask) - bias), 1'b0});
        cnt -= w;
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      if (eos || cnt > 7) begin
        model_carry     = '0;
        model_carry_cnt = '0;
      end else begin
        model_carry     = 7'(acc & ((1 << cnt) - 1));
        model_carry_cnt = 3'(cnt);
      end
    end
    if (keep) foreach (outs[i]) pending_weights.push_back(outs[i]);
  endtask

  // Called at a falling edge; returns at a falling edge with the block idle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_weights.size() != 0) @(negedge clk_i);
    repeat (DrainGap) @(negedge clk_i);
  endtask

  task automatic write_width(input logic [3:0] w);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_width     = w;
    model_carry     = '0;
    model_carry_cnt = '0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic eos, input logic [1:0] n_typed,
                           input logic [7:0] v0, input logic [7:0] v1);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= eos;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    unpack_byte(data, eos, n_typed == 2'd0);
    if (n_typed == 2'd1) begin
      pending_weights.push_back('{v0, 1'b1});
    end else if (n_typed == 2'd2) begin
      pending_weights.push_back('{v0, 1'b0});
      pending_weights.push_back('{v1, 1'b1});
    end
    @(negedge clk_i);
  endtask

  // receiver: random stall bursts, plus one long hold on request
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_asks != holds_done) begin
      holds_done++;
      stall_left = LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_weights.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected weight %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        exp_w = pending_weights.pop_front();
        if (m_axis_tdata !== exp_w.value || m_axis_tlast !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("weight mismatch: expected %h last %b, got %h last %b",
                     exp_w.value, exp_w.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    int         phase, k, n, r;
    logic [3:0] w;
    logic [7:0] b;
    logic       e;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_vecs[i]) begin
      if (directed_vecs[i].set_w) write_width(directed_vecs[i].width);
      send_byte(directed_vecs[i].data, directed_vecs[i].eos, directed_vecs[i].n_typed,
                directed_vecs[i].v0, directed_vecs[i].v1);
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      r = $urandom_range(0, 11);
      if (phase == 0) w = 4'd1;
      else if (phase == 1) w = 4'd8;
      else if (r < 8) w = 4'(r + 1);
      else if (r == 8) w = 4'd0;
      else w = 4'($urandom_range(9, 15));
      write_width(w);
      calm = (phase >= NumPhases - 3);
      n = $urandom_range(8, 20);
      for (k = 0; k < n; k++) begin
        if (phase == 5 && k == 2) hold_asks++;
        if (phase == 9 && k == n / 2) drain_results();
        r = $urandom_range(0, 7);
        if (r == 0) b = 8'h00;
        else if (r == 1) b = 8'hFF;
        else b = 8'($urandom_range(0, 255));
        e = ($urandom_range(0, 9) == 0) || (k == n - 1 && $urandom_range(0, 1) == 1);
        send_byte(b, e, 2'd0, 8'h00, 8'h00);
      end
    end

    drain_results();
    repeat (EndGap) @(negedge clk_i);
    if (mismatches == 0 && pending_weights.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lbwu_pkg.sv
rtl/lbwu_slicer.sv
rtl/low_bit_weight_unpacker.sv
bench/low_bit_weight_unpacker_tb.sv
